/* design/ttag_pkg.sv */
package ttag_pkg;

	// Fixed field widths of the block.
	localparam int NREG_DIMS      = 4;
	localparam int DIM_BITS       = 16;
	localparam int VALUE_BITS     = 32;
	localparam int RANK_BITS      = 3;
	localparam int PERM_BITS      = 8;
	localparam int OUT_ADDR_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_DIM0 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_DIM1 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_DIM2 = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIZE_DIM3 = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PERM      = 3'd5;

	// Reset values of the registers.
	localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd4;
	localparam logic [DIM_BITS-1:0]  SIZE_RESET = 16'd1;
	localparam logic [PERM_BITS-1:0] PERM_RESET = 8'd228;

	typedef struct packed {
		logic [RANK_BITS-1:0]                rank;
		logic [NREG_DIMS-1:0][DIM_BITS-1:0] size;
		logic [PERM_BITS-1:0]                perm;
	} ttag_cfg_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} ttag_seq_state_t;

	// Rank in use: zero counts as one, anything above the limit saturates.
	function automatic logic [RANK_BITS-1:0] ttag_eff_rank(
		input logic [RANK_BITS-1:0] rank,
		input logic [RANK_BITS-1:0] lim
	);
		logic [RANK_BITS-1:0] r;
		r = rank;
		if (r == '0) begin
			r = 3'd1;
		end
		if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

endpackage

/* design/ttag_if.sv */
interface ttag_elem_if;
	import ttag_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  first_of_tensor;

	modport source(output valid, output value, output first_of_tensor, input ready);
	modport sink(input valid, input value, input first_of_tensor, output ready);
endinterface

interface ttag_result_if;
	import ttag_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OUT_ADDR_BITS-1:0] dest_address;
	logic [VALUE_BITS-1:0]    data_out;
	logic                     in_range;
	logic                     last_of_tensor;

	modport source(
		output valid, output dest_address, output data_out, output in_range,
		output last_of_tensor, input ready
	);
	modport sink(
		input valid, input dest_address, input data_out, input in_range,
		input last_of_tensor, output ready
	);
endinterface

/* design/tensor_transpose_address_gen_unit.sv */
// Channel     Role    Transaction                   Payload
// element     sink    one source tensor element     value, first_of_tensor
// result      source  one placed element            dest_address, data_out,
//                                                   in_range, last_of_tensor
// cfg_write   sink    one register write, no wait   cfg_index, cfg_data
//
// One element is accepted per cycle while the port is not held off, and one
// result leaves per cycle once the pipeline is full and the sink is ready;
// an element passes the queue, the product register, the pair-sum register
// and the output register before its result is presented.
// The element port is held off in the cycle of every write to a listed
// register and while the stride sequencer then rebuilds the strides.
// Reset restores rank four, unit extents and the identity permutation.
// A four-entry queue between the position counter and the address pipeline
// absorbs back-pressure; the element port also stalls when that queue fills.
module tensor_transpose_address_gen_unit
	import ttag_pkg::*;
#(
	parameter int MAX_RANK  = 4,
	parameter int ADDR_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	ttag_elem_if.sink                 element,
	ttag_result_if.source             result
);

	// Number of digit lanes in hardware: the rank can never exceed the four
	// extent registers, whatever MAX_RANK allows.
	localparam int LIM = (MAX_RANK < NREG_DIMS) ? MAX_RANK : NREG_DIMS;
	// Address arithmetic width. Wrapping at more than 32 bits and then keeping
	// the low 32 is the same as wrapping at 32, so the datapath stops there.
	localparam int AW  = (ADDR_BITS < OUT_ADDR_BITS) ? ADDR_BITS : OUT_ADDR_BITS;

	// One queue entry: the source position seen by each output dimension
	// (zero for dimensions out of use and for elements out of range), the
	// raw value and the two flags.
	typedef struct packed {
		logic [LIM-1:0][DIM_BITS-1:0] pos;
		logic [VALUE_BITS-1:0]        value;
		logic                         in_range;
		logic                         last;
	} ttag_job_t;

	ttag_cfg_t              cfg_q;
	logic                   cfg_change;
	logic                   stride_busy;
	logic [LIM-1:0][AW-1:0] stride;
	logic                   push;
	logic                   pop;
	logic                   full;
	logic                   empty;
	ttag_job_t              job_in;
	ttag_job_t              job_out;

	// Configuration registers. A write to an index beyond the list is
	// dropped and leaves the strides alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank <= RANK_RESET;
			cfg_q.size <= {NREG_DIMS{SIZE_RESET}};
			cfg_q.perm <= PERM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RANK:      cfg_q.rank    <= cfg_data[RANK_BITS-1:0];
				REG_SIZE_DIM0: cfg_q.size[0] <= cfg_data[DIM_BITS-1:0];
				REG_SIZE_DIM1: cfg_q.size[1] <= cfg_data[DIM_BITS-1:0];
				REG_SIZE_DIM2: cfg_q.size[2] <= cfg_data[DIM_BITS-1:0];
				REG_SIZE_DIM3: cfg_q.size[3] <= cfg_data[DIM_BITS-1:0];
				REG_PERM:      cfg_q.perm    <= cfg_data[PERM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_change = cfg_write && (cfg_index <= REG_PERM);

	// The stride of each output dimension is the product of the permuted
	// extents inside it. Those products only change with the registers, so a
	// small sequencer works them out once per write, one multiply per cycle,
	// instead of a chain of multipliers in the element path.
	ttag_stride #(
		.LIM(LIM),
		.AW (AW)
	) u_stride (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.start (cfg_change),
		.busy  (stride_busy),
		.stride(stride)
	);

	// Front: the multi-digit position counter. It classifies each element
	// (in range, last), advances the counter and gathers the permuted
	// positions, all in the cycle of the transaction.
	ttag_front #(
		.LIM  (LIM),
		.job_t(ttag_job_t)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.hold   (stride_busy),
		.full   (full),
		.element(element),
		.push   (push),
		.job    (job_in)
	);

	ttag_queue #(
		.entry_t(ttag_job_t),
		.DEPTH  (4)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.pop   (pop),
		.rdata (job_out),
		.full  (full),
		.empty (empty)
	);

	// Back: one multiplier per output dimension, then a two-level adder
	// tree, the last level being the output register.
	ttag_back #(
		.LIM  (LIM),
		.AW   (AW),
		.job_t(ttag_job_t)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.stride(stride),
		.empty (empty),
		.job   (job_out),
		.pop   (pop),
		.result(result)
	);

endmodule

/* design/ttag_stride.sv */
module ttag_stride
	import ttag_pkg::*;
#(
	parameter int LIM = 4,
	parameter int AW  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ttag_cfg_t              cfg,
	input  logic                   start,
	output logic                   busy,
	output logic [LIM-1:0][AW-1:0] stride
);

	localparam int KW = (LIM > 1) ? $clog2(LIM) : 1;

	ttag_seq_state_t        state_q, state_next;
	logic [KW-1:0]          k_q;
	logic [AW-1:0]          acc_q;
	logic [LIM-1:0][AW-1:0] stride_q;
	logic                   step;
	logic [RANK_BITS-1:0]   r;
	logic [1:0]             src;
	logic                   lane_live;
	logic [DIM_BITS-1:0]    ext;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_next = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				if (!start && k_q == '0) begin
					state_next = SEQ_IDLE;
				end
			end
			default: state_next = SEQ_IDLE;
		endcase
	end

	always_comb begin
		step = (state_q == SEQ_RUN) && !start;
		busy = (state_q == SEQ_RUN) || start;
	end

	// Extent of the output dimension at the current step; lanes beyond the
	// rank and selectors at or above it count as extent one.
	always_comb begin
		r         = ttag_eff_rank(cfg.rank, RANK_BITS'(LIM));
		src       = '0;
		lane_live = 1'b0;
		for (int k = 0; k < LIM; k++) begin
			if (k_q == KW'(k)) begin
				src       = cfg.perm[2*k +: 2];
				lane_live = RANK_BITS'(k) < r;
			end
		end
		ext = (lane_live && {1'b0, src} < r) ? cfg.size[src] : DIM_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SEQ_IDLE;
			k_q      <= '0;
			acc_q    <= AW'(1);
			stride_q <= {LIM{AW'(1)}};
		end else begin
			state_q <= state_next;
			if (start) begin
				acc_q <= AW'(1);
				k_q   <= KW'(LIM - 1);
			end else if (step) begin
				stride_q[k_q] <= acc_q;
				acc_q         <= AW'(acc_q * ext);
				k_q           <= k_q - KW'(1);
			end
		end
	end

	assign stride = stride_q;

endmodule

/* design/ttag_front.sv */
module ttag_front
	import ttag_pkg::*;
#(
	parameter int  LIM   = 4,
	parameter type job_t = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ttag_cfg_t cfg,
	input  logic      hold,
	input  logic      full,
	ttag_elem_if.sink element,
	output logic      push,
	output job_t      job
);

	logic [LIM-1:0][DIM_BITS-1:0] digit_q;
	logic                         past_q;
	logic [LIM-1:0][DIM_BITS-1:0] digits_cur;
	logic [LIM-1:0][DIM_BITS-1:0] digits_nxt;
	logic                         past_cur;
	logic                         inr;
	logic                         last;
	logic                         carry;
	logic [RANK_BITS-1:0]         r;

	assign element.ready = !hold && !full;
	assign push          = element.valid && element.ready;

	always_comb begin
		logic [DIM_BITS:0] inc;
		logic [1:0]        src;
		r          = ttag_eff_rank(cfg.rank, RANK_BITS'(LIM));
		digits_cur = element.first_of_tensor ? '0 : digit_q;
		past_cur   = element.first_of_tensor ? 1'b0 : past_q;

		inr  = !past_cur;
		last = 1'b1;
		for (int d = 0; d < LIM; d++) begin
			if (RANK_BITS'(d) < r) begin
				if (digits_cur[d] >= cfg.size[d]) begin
					inr = 1'b0;
				end
				if ({1'b0, digits_cur[d]} + 17'd1 != {1'b0, cfg.size[d]}) begin
					last = 1'b0;
				end
			end
		end
		last = last && inr;

		// Innermost digit steps first; a wrap carries outwards.
		carry      = 1'b1;
		digits_nxt = digits_cur;
		inc        = '0;
		for (int d = LIM - 1; d >= 0; d--) begin
			if (RANK_BITS'(d) < r && carry) begin
				inc = {1'b0, digits_cur[d]} + 17'd1;
				if (inc >= {1'b0, cfg.size[d]}) begin
					digits_nxt[d] = '0;
				end else begin
					digits_nxt[d] = inc[DIM_BITS-1:0];
					carry         = 1'b0;
				end
			end
		end

		job       = '0;
		src       = '0;
		for (int k = 0; k < LIM; k++) begin
			src = cfg.perm[2*k +: 2];
			if (inr && RANK_BITS'(k) < r) begin
				for (int d = 0; d < LIM; d++) begin
					if (src == 2'(d) && RANK_BITS'(d) < r) begin
						job.pos[k] = digits_cur[d];
					end
				end
			end
		end
		job.value    = element.value;
		job.in_range = inr;
		job.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			past_q  <= 1'b0;
		end else if (push) begin
			if (inr) begin
				digit_q <= digits_nxt;
				past_q  <= carry;
			end else begin
				digit_q <= digits_cur;
				past_q  <= 1'b1;
			end
		end
	end

endmodule

/* design/ttag_queue.sv */
module ttag_queue #(
	parameter type entry_t = logic,
	parameter int  DEPTH   = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	input  logic   pop,
	output entry_t rdata,
	output logic   full,
	output logic   empty
);

	// DEPTH must be a power of two so that the pointers wrap by themselves; the queue itself does not check this.
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW + 1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end

endmodule

/* design/ttag_back.sv */
module ttag_back
	import ttag_pkg::*;
#(
	parameter int  LIM   = 4,
	parameter int  AW    = 32,
	parameter type job_t = logic
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [LIM-1:0][AW-1:0] stride,
	input  logic                   empty,
	input  job_t                   job,
	output logic                   pop,
	ttag_result_if.source          result
);

	localparam int NP = (LIM + 1) / 2;

	logic                    valid_s1, valid_s2, valid_s3;
	logic                    adv1, adv2, adv3;
	logic [LIM-1:0][AW-1:0]  prod_s1;
	logic [VALUE_BITS-1:0]   value_s1, value_s2, value_s3;
	logic                    inr_s1, inr_s2, inr_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [2*NP-1:0][AW-1:0] prod_pad;
	logic [NP-1:0][AW-1:0]   pair_s2;
	logic [AW-1:0]           addr_sum;
	logic [AW-1:0]           addr_s3;

	// A stage takes new data when it is empty or its content moves on.
	assign adv3 = !valid_s3 || result.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign pop  = !empty && adv1;

	always_comb begin
		prod_pad = '0;
		for (int k = 0; k < LIM; k++) begin
			prod_pad[k] = prod_s1[k];
		end
	end

	always_comb begin
		addr_sum = '0;
		for (int i = 0; i < NP; i++) begin
			addr_sum = addr_sum + pair_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= !empty;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int k = 0; k < LIM; k++) begin
				prod_s1[k] <= AW'(job.pos[k] * stride[k]);
			end
			value_s1 <= job.value;
			inr_s1   <= job.in_range;
			last_s1  <= job.last;
		end
		if (adv2 && valid_s1) begin
			for (int i = 0; i < NP; i++) begin
				pair_s2[i] <= prod_pad[2*i] + prod_pad[2*i+1];
			end
			value_s2 <= value_s1;
			inr_s2   <= inr_s1;
			last_s2  <= last_s1;
		end
		if (adv3 && valid_s2) begin
			addr_s3  <= addr_sum;
			value_s3 <= value_s2;
			inr_s3   <= inr_s2;
			last_s3  <= last_s2;
		end
	end

	assign result.valid          = valid_s3;
	assign result.dest_address   = OUT_ADDR_BITS'(addr_s3);
	assign result.data_out       = value_s3;
	assign result.in_range       = inr_s3;
	assign result.last_of_tensor = last_s3;

endmodule
